### rtl/rrsd_pkg.sv
// Shared types, constants and the float32 formatter for the RGBE scanline decoder.
// No dependencies; used by rgbe_rle_scanline_decoder_core.
`default_nettype none

package rrsd_pkg;

  localparam int MaxWidthDefault = 4096;
  localparam int PosW = 13;
  localparam logic [PosW-1:0] WidthReset = 13'd256;
  localparam logic [7:0] HeaderMark = 8'd2;
  localparam logic [7:0] RunBase = 8'd128;

  // position in the scanline byte grammar
  typedef enum logic [2:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_CODE, PH_RUNVAL, PH_LIT
  } phase_t;

  // sequencer around the line store
  typedef enum logic [2:0] {
    S_IDLE, S_FILL, S_RD0, S_RD1, S_RD2, S_EMIT
  } ctrl_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_HEADER, ERR_RUN
  } err_t;

  // exact float32 bits of val * 2^(e-136)
  function automatic logic [31:0] to_float(input logic [7:0] val, input logic [7:0] e);
    logic [2:0]  p;
    logic [9:0]  se;
    logic [30:0] aligned;
    logic [31:0] r;
    p = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (val[i]) p = 3'(i);
    end
    se = 10'(p) + 10'(e);
    aligned = {val, 23'd0} >> p;
    if (val == 8'd0) begin
      r = 32'd0;
    end else if (se >= 10'd10) begin
      r = {1'b0, 8'(se - 10'd9), aligned[22:0]};
    end else begin
      // denormal: exponent is below 10 here
      r = 32'(val) << (5'(e) + 5'd13);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/rgbe_rle_scanline_decoder_core.sv
// Top level of the RGBE run-length scanline decoder.
// Depends on rrsd_pkg and rrsd_line_store.
`default_nettype none

// One input byte is taken per cycle for header bytes, code bytes and literal
// R/G/B bytes, unless the output is stalled. A run of color bytes holds the
// input while the line store is written one pixel a cycle. Every exponent
// byte, literal or run, reads the line store for its pixels: a pair is read
// in S_RD0, S_RD1 and S_RD2, then loaded into the output register in S_EMIT,
// which waits while the output is stalled. Results carry up to two pixels; a
// header mismatch or a run past the line width gives one error-only request
// ahead of any pixels. Store entries are not cleared at reset.
module rgbe_rle_scanline_decoder_core #(
  parameter int MAX_WIDTH = rrsd_pkg::MaxWidthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [12:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      first_red,
  output logic [31:0]      first_green,
  output logic [31:0]      first_blue,
  output logic [31:0]      second_red,
  output logic [31:0]      second_green,
  output logic [31:0]      second_blue,
  output logic [1:0]       pixel_count,
  output logic             line_end,
  output logic [1:0]       error_code
);

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int PW = rrsd_pkg::PosW;

  // state
  rrsd_pkg::phase_t phase, phase_next;
  rrsd_pkg::ctrl_t  ctrl, ctrl_next;
  logic [1:0]       ch, ch_next;
  logic [PW-1:0]    pos, pos_next;
  logic [7:0]       pend, pend_next;
  logic [7:0]       whi, whi_next;
  logic             hbad, hbad_next;
  logic [PW-1:0]    line_width;
  logic [6:0]       n, n_next;
  logic [7:0]       vbyte, vbyte_next;
  logic             two, two_next;
  logic [23:0]      rgba, rgba_next, rgbb, rgbb_next;

  // store port
  logic [2:0]       st_we;
  logic             st_re;
  logic [23:0]      st_rdata;

  // output load
  logic             load_err, load_pix;
  rrsd_pkg::err_t   err_sel;

  logic in_acc, out_free;
  logic [PW-1:0] w, avail, run_len;
  logic [7:0] code_cnt;
  logic [PW-1:0] hdr_width;
  logic step_done;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (ctrl != rrsd_pkg::S_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  // effective width
  always_comb begin
    if (line_width == '0) begin
      w = PW'(1);
    end else if (32'(line_width) > MAX_WIDTH) begin
      w = PW'(MAX_WIDTH);
    end else begin
      w = line_width;
    end
  end

  assign avail     = (pos < w) ? w - pos : '0;
  assign code_cnt  = (data_byte > rrsd_pkg::RunBase) ? {1'b0, data_byte[6:0]} : data_byte;
  assign run_len   = (PW'(pend) > avail) ? avail : PW'(pend);
  assign hdr_width = PW'({whi, data_byte});

  rrsd_line_store #(.Depth(MAX_WIDTH)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (AddrW'(pos)),
    .wbyte ((ctrl == rrsd_pkg::S_FILL) ? vbyte : data_byte),
    .re    (st_re),
    .raddr (AddrW'(pos)),
    .rdata (st_rdata)
  );

  // sequencer next state
  always_comb begin
    ctrl_next = ctrl;
    case (ctrl)
      rrsd_pkg::S_IDLE: begin
        if (in_acc && phase == rrsd_pkg::PH_RUNVAL && run_len != '0) begin
          ctrl_next = (ch == 2'd3) ? rrsd_pkg::S_RD0 : rrsd_pkg::S_FILL;
        end else if (in_acc && phase == rrsd_pkg::PH_LIT && pos < w && ch == 2'd3) begin
          ctrl_next = rrsd_pkg::S_RD0;
        end
      end
      rrsd_pkg::S_FILL: if (n == 7'd1) ctrl_next = rrsd_pkg::S_IDLE;
      rrsd_pkg::S_RD0:  ctrl_next = rrsd_pkg::S_RD1;
      rrsd_pkg::S_RD1:  ctrl_next = (n != '0) ? rrsd_pkg::S_RD2 : rrsd_pkg::S_EMIT;
      rrsd_pkg::S_RD2:  ctrl_next = rrsd_pkg::S_EMIT;
      rrsd_pkg::S_EMIT: begin
        if (out_free) ctrl_next = (n != '0) ? rrsd_pkg::S_RD0 : rrsd_pkg::S_IDLE;
      end
      default: ctrl_next = rrsd_pkg::S_IDLE;
    endcase
  end

  // datapath and store controls
  always_comb begin
    phase_next = phase;
    ch_next    = ch;
    pos_next   = pos;
    pend_next  = pend;
    whi_next   = whi;
    hbad_next  = hbad;
    n_next     = n;
    vbyte_next = vbyte;
    two_next   = two;
    rgba_next  = rgba;
    rgbb_next  = rgbb;
    st_we      = '0;
    st_re      = 1'b0;
    load_err   = 1'b0;
    load_pix   = 1'b0;
    err_sel    = rrsd_pkg::ERR_NONE;
    case (ctrl)
      rrsd_pkg::S_IDLE: begin
        if (in_acc) begin
          case (phase)
            rrsd_pkg::PH_H0: begin
              hbad_next  = (data_byte != rrsd_pkg::HeaderMark);
              phase_next = rrsd_pkg::PH_H1;
            end
            rrsd_pkg::PH_H1: begin
              if (data_byte != rrsd_pkg::HeaderMark) hbad_next = 1'b1;
              phase_next = rrsd_pkg::PH_H2;
            end
            rrsd_pkg::PH_H2: begin
              whi_next   = data_byte;
              phase_next = rrsd_pkg::PH_H3;
            end
            rrsd_pkg::PH_H3: begin
              if (hbad || whi[7:PW-8] != '0 || hdr_width != w) begin
                load_err = 1'b1;
                err_sel  = rrsd_pkg::ERR_HEADER;
              end
              hbad_next  = 1'b0;
              ch_next    = '0;
              pos_next   = '0;
              phase_next = rrsd_pkg::PH_CODE;
            end
            rrsd_pkg::PH_CODE: begin
              pend_next = code_cnt;
              if (data_byte > rrsd_pkg::RunBase) begin
                phase_next = rrsd_pkg::PH_RUNVAL;
              end else if (data_byte == '0) begin
                phase_next = rrsd_pkg::PH_CODE;
              end else begin
                phase_next = rrsd_pkg::PH_LIT;
              end
              if (PW'(code_cnt) > avail) begin
                load_err = 1'b1;
                err_sel  = rrsd_pkg::ERR_RUN;
              end
            end
            rrsd_pkg::PH_RUNVAL: begin
              pend_next  = '0;
              phase_next = rrsd_pkg::PH_CODE;
              vbyte_next = data_byte;
              n_next     = run_len[6:0];
            end
            rrsd_pkg::PH_LIT: begin
              pend_next = pend - 8'd1;
              if (pend == 8'd1) phase_next = rrsd_pkg::PH_CODE;
              if (pos < w) begin
                if (ch == 2'd3) begin
                  vbyte_next = data_byte;
                  n_next     = 7'd1;
                end else begin
                  st_we    = 3'b100 >> ch;
                  pos_next = pos + PW'(1);
                end
              end
            end
            default: phase_next = rrsd_pkg::PH_H0;
          endcase
        end
      end
      rrsd_pkg::S_FILL: begin
        st_we    = 3'b100 >> ch;
        pos_next = pos + PW'(1);
        n_next   = n - 7'd1;
      end
      rrsd_pkg::S_RD0: begin
        st_re    = 1'b1;
        pos_next = pos + PW'(1);
        n_next   = n - 7'd1;
      end
      rrsd_pkg::S_RD1: begin
        rgba_next = st_rdata;
        two_next  = 1'b0;
        if (n != '0) begin
          st_re    = 1'b1;
          pos_next = pos + PW'(1);
          n_next   = n - 7'd1;
        end
      end
      rrsd_pkg::S_RD2: begin
        rgbb_next = st_rdata;
        two_next  = 1'b1;
      end
      rrsd_pkg::S_EMIT: begin
        load_pix = out_free;
      end
      default: ;
    endcase

    // end of channel once a step completes
    step_done = (ctrl_next == rrsd_pkg::S_IDLE) &&
                ((ctrl == rrsd_pkg::S_IDLE) ? in_acc : 1'b1);
    if (step_done && phase_next == rrsd_pkg::PH_CODE && pos_next >= w) begin
      pos_next = '0;
      if (ch_next == 2'd3) begin
        ch_next    = '0;
        phase_next = rrsd_pkg::PH_H0;
      end else begin
        ch_next = ch_next + 2'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= rrsd_pkg::PH_H0;
      ctrl       <= rrsd_pkg::S_IDLE;
      ch         <= '0;
      pos        <= '0;
      pend       <= '0;
      whi        <= '0;
      hbad       <= 1'b0;
      n          <= '0;
      line_width <= rrsd_pkg::WidthReset;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      ctrl  <= ctrl_next;
      ch    <= ch_next;
      pos   <= pos_next;
      pend  <= pend_next;
      whi   <= whi_next;
      hbad  <= hbad_next;
      n     <= n_next;
      if (cfg_write) line_width <= cfg_data;
      if (load_err || load_pix) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pixel holding registers
  always_ff @(posedge clk) begin
    vbyte <= vbyte_next;
    two   <= two_next;
    rgba  <= rgba_next;
    rgbb  <= rgbb_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_err) begin
      first_red    <= '0;
      first_green  <= '0;
      first_blue   <= '0;
      second_red   <= '0;
      second_green <= '0;
      second_blue  <= '0;
      pixel_count  <= 2'd0;
      line_end     <= 1'b0;
      error_code   <= err_sel;
    end else if (load_pix) begin
      first_red    <= rrsd_pkg::to_float(rgba[23:16], vbyte);
      first_green  <= rrsd_pkg::to_float(rgba[15:8], vbyte);
      first_blue   <= rrsd_pkg::to_float(rgba[7:0], vbyte);
      second_red   <= two ? rrsd_pkg::to_float(rgbb[23:16], vbyte) : '0;
      second_green <= two ? rrsd_pkg::to_float(rgbb[15:8], vbyte) : '0;
      second_blue  <= two ? rrsd_pkg::to_float(rgbb[7:0], vbyte) : '0;
      pixel_count  <= two ? 2'd2 : 2'd1;
      line_end     <= (pos == w);
      error_code   <= rrsd_pkg::ERR_NONE;
    end
  end

`ifndef NO_ASSERTIONS
  // input is only taken by an idle sequencer
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> ctrl == rrsd_pkg::S_IDLE)
    else $error("input taken while sequencer busy");

  // error requests carry no pixels
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != rrsd_pkg::ERR_NONE) |-> pixel_count == 2'd0)
    else $error("error request with pixels");

  // pixel requests hold one or two pixels
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code == rrsd_pkg::ERR_NONE) |->
      (pixel_count == 2'd1 || pixel_count == 2'd2))
    else $error("bad pixel count");

  // a fill never starts with nothing to write
  assert property (@(posedge clk) disable iff (rst)
    ctrl == rrsd_pkg::S_FILL |-> n != '0)
    else $error("empty fill");

  // a loaded output is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(pixel_count))
    else $error("output overwritten while stalled");
`endif

endmodule

`default_nettype wire

### rtl/rrsd_line_store.sv
// Line store: one 24-bit word per pixel (R 23:16, G 15:8, B 7:0), byte-lane writes.
// Synchronous read. Depends on nothing.
`default_nettype none

module rrsd_line_store #(
  parameter int Depth = 4096
) (
  input  wire logic                     clk,
  input  wire logic [2:0]               we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [7:0]               wbyte,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [23:0]              rdata
);

  logic [23:0] mem [Depth];

  // lane writes, one enable per byte lane
  always_ff @(posedge clk) begin
    if (we[2]) mem[waddr][23:16] <= wbyte;
    if (we[1]) mem[waddr][15:8] <= wbyte;
    if (we[0]) mem[waddr][7:0] <= wbyte;
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
